@@ sv/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared assertion macros. Clock is clk, reset is rst_n (active low).
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Combinational property checked at every rising clock edge outside reset
`define ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent in the next cycle
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

@@ sv/ncpm_pkg.sv @@
// ----------------------------------------------------------------------------
// ncpm_pkg
// Types, codes and helper functions of the nearest color pixel mapper.
// ----------------------------------------------------------------------------
package ncpm_pkg;

    localparam int CHAN_W = 16;
    localparam int PIX_W  = 16;
    localparam int DIST_W = 34;
    localparam int BEST_W = 28;
    localparam logic [BEST_W-1:0] BEST_START = 28'h0FFFFFFF;

    // Request opcodes
    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    // Color modes
    localparam logic [1:0] MODE_PALETTE = 2'd0;
    localparam logic [1:0] MODE_DIRECT  = 2'd1;

    // Register indexes
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_COLOR_MODE   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BITS_PER_RGB = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PALETTE_SIZE = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_RED_MASK     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_GREEN_MASK   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_BLUE_MASK    = 3'd5;
    localparam int CFG_DATA_W = 16;

    typedef struct packed {
        logic              op;
        logic [7:0]        entry_index;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } in_req_t;

    typedef struct packed {
        logic [PIX_W-1:0] pixel;
        logic             ok;
    } out_rsp_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DONE
    } state_t;

    // Leading zeros of a 16-bit mask, 0 for an all-zero mask
    function automatic logic [3:0] lead_zeros16(input logic [15:0] mask);
        logic [3:0] n;
        n = 4'd0;
        for (int i = 0; i < 16; i++) begin
            if (mask[i])
            begin
                n = 4'(15 - i);
            end
        end
        return n;
    endfunction

    // Absolute difference of two channels
    function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                   input logic [CHAN_W-1:0] b);
        return (a >= b) ? (a - b) : (b - a);
    endfunction

endpackage

@@ sv/nearest_color_pixel_mapper_top.sv @@
// ----------------------------------------------------------------------------
// nearest_color_pixel_mapper_top
// Maps a 16-bit-per-channel RGB color to a pixel: nearest palette entry by
// squared distance, or direct packing through three channel masks.
//
//   channel   signals                           direction  meaning
//   in        in_valid/in_ready/in_data         sink       lookup or palette write
//   out       out_valid/out_ready/out_data      source     pixel and ok, per lookup
//   cfg       cfg_we/cfg_index/cfg_wdata        sink       register write
//
// Palette writes and direct or unsupported lookups finish at accept.
// A palette lookup searches min(palette_size, PALETTE_DEPTH) entries, read
// from the palette memory one entry per cycle through a four stage
// read/shift-difference/square/compare pipeline.
// Reset clears control and loads the register defaults; the palette memory
// is not cleared. A full output register holds back lookups that finish.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module nearest_color_pixel_mapper_top
    import ncpm_pkg::*;
#(
    parameter int PALETTE_DEPTH = 256
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_req_t              in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_rsp_t             out_data,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int ADDR_W = $clog2(PALETTE_DEPTH);
    localparam int CNT_W  = $clog2(PALETTE_DEPTH + 1);
    localparam int CMP_W  = (CNT_W > 9) ? CNT_W : 9;
    localparam int IDX_W  = (ADDR_W + 1 > 8) ? ADDR_W + 1 : 8;
    localparam int ENT_W  = 3 * CHAN_W;

    // Configuration registers
    logic [1:0]        color_mode_reg;
    logic [4:0]        bits_per_rgb_reg;
    logic [8:0]        palette_size_reg;
    logic [CHAN_W-1:0] red_mask_reg;
    logic [CHAN_W-1:0] green_mask_reg;
    logic [CHAN_W-1:0] blue_mask_reg;
    logic [3:0]        red_lz_reg;
    logic [3:0]        green_lz_reg;
    logic [3:0]        blue_lz_reg;

    // Control
    state_t            state_reg;
    state_t            state_next;
    logic [CNT_W-1:0]  issue_cnt_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [3:0]        sh_reg;
    logic [CHAN_W-1:0] tgt_r_reg;
    logic [CHAN_W-1:0] tgt_g_reg;
    logic [CHAN_W-1:0] tgt_b_reg;

    // Scan pipeline
    logic [ENT_W-1:0]  mem_rdata_reg;
    logic              v1_reg;
    logic              v2_reg;
    logic              v3_reg;
    logic [ADDR_W-1:0] idx1_reg;
    logic [ADDR_W-1:0] idx2_reg;
    logic [ADDR_W-1:0] idx3_reg;
    logic [CHAN_W-1:0] d_r_reg;
    logic [CHAN_W-1:0] d_g_reg;
    logic [CHAN_W-1:0] d_b_reg;
    logic [31:0]       sq_r_reg;
    logic [31:0]       sq_g_reg;
    logic [31:0]       sq_b_reg;
    logic [BEST_W-1:0] best_reg;
    logic [ADDR_W-1:0] best_idx_reg;

    // Output register
    logic              out_valid_reg;
    out_rsp_t          out_data_reg;

    // Palette memory, {red, green, blue}
    logic [ENT_W-1:0]  mem [PALETTE_DEPTH];

    logic              accept;
    logic              slot_free;
    logic              needs_slot;
    logic              is_palette;
    logic [CNT_W-1:0]  count_eff;
    logic [CMP_W-1:0]  ps_ext;
    logic [4:0]        bits_c;
    logic [3:0]        sh_eff;
    logic [IDX_W-1:0]  wr_idx_ext;
    logic              mem_we;
    logic [ADDR_W-1:0] wr_addr;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              out_load;
    out_rsp_t          out_load_data;
    logic [PIX_W-1:0]  direct_pix;
    logic [DIST_W-1:0] dist_sum;
    logic              better;

    // Effective search length and channel shift
    always_comb
    begin
        ps_ext = CMP_W'(palette_size_reg);
        if (ps_ext > CMP_W'(PALETTE_DEPTH))
        begin
            count_eff = CNT_W'(PALETTE_DEPTH);
        end
        else
        begin
            count_eff = CNT_W'(ps_ext);
        end
        if (bits_per_rgb_reg == 5'd0)
        begin
            bits_c = 5'd1;
        end
        else if (bits_per_rgb_reg > 5'd16)
        begin
            bits_c = 5'd16;
        end
        else
        begin
            bits_c = bits_per_rgb_reg;
        end
        sh_eff = 4'(5'd16 - bits_c);
    end

    // Direct packing
    assign direct_pix = ((in_data.red   >> red_lz_reg)   & red_mask_reg)
                      | ((in_data.green >> green_lz_reg) & green_mask_reg)
                      | ((in_data.blue  >> blue_lz_reg)  & blue_mask_reg);

    // Request acceptance
    assign slot_free  = !out_valid_reg || out_ready;
    assign is_palette = (color_mode_reg == MODE_PALETTE) && (count_eff != '0);
    assign needs_slot = (in_data.op == OP_LOOKUP) && !is_palette;
    assign in_ready   = (state_reg == ST_IDLE) && (!needs_slot || slot_free);
    assign accept     = in_valid && in_ready;

    // Palette write address
    assign wr_idx_ext = IDX_W'(in_data.entry_index);
    assign wr_addr    = wr_idx_ext[ADDR_W-1:0];
    assign mem_we     = accept && (in_data.op == OP_WRITE)
                      && (wr_idx_ext < IDX_W'(PALETTE_DEPTH));

    // Scan read port
    assign rd_en   = (state_reg == ST_SCAN) && (issue_cnt_reg < count_reg);
    assign rd_addr = issue_cnt_reg[ADDR_W-1:0];

    // Distance of the entry in the last stage
    assign dist_sum = DIST_W'(sq_r_reg) + DIST_W'(sq_g_reg) + DIST_W'(sq_b_reg);
    assign better   = v3_reg && (dist_sum < DIST_W'(best_reg));

    // Next state and output load
    always_comb
    begin
        state_next    = state_reg;
        out_load      = 1'b0;
        out_load_data = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept && (in_data.op == OP_LOOKUP))
                begin
                    if (is_palette)
                    begin
                        state_next = ST_SCAN;
                    end
                    else
                    begin
                        out_load = 1'b1;
                        if (color_mode_reg == MODE_PALETTE)
                        begin
                            out_load_data.ok = 1'b1;
                        end
                        else if (color_mode_reg == MODE_DIRECT)
                        begin
                            out_load_data.pixel = direct_pix;
                            out_load_data.ok    = 1'b1;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                if ((issue_cnt_reg == count_reg) && !v1_reg && !v2_reg && !v3_reg)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (slot_free)
                begin
                    out_load            = 1'b1;
                    out_load_data.pixel = PIX_W'(best_idx_reg);
                    out_load_data.ok    = 1'b1;
                    state_next          = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            color_mode_reg   <= MODE_DIRECT;
            bits_per_rgb_reg <= 5'd8;
            palette_size_reg <= 9'd256;
            red_mask_reg     <= 16'hF800;
            green_mask_reg   <= 16'h07E0;
            blue_mask_reg    <= 16'h001F;
            red_lz_reg       <= 4'd0;
            green_lz_reg     <= 4'd5;
            blue_lz_reg      <= 4'd11;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_COLOR_MODE:   color_mode_reg   <= cfg_wdata[1:0];
                CFG_BITS_PER_RGB: bits_per_rgb_reg <= cfg_wdata[4:0];
                CFG_PALETTE_SIZE: palette_size_reg <= cfg_wdata[8:0];
                CFG_RED_MASK:
                begin
                    red_mask_reg <= cfg_wdata;
                    red_lz_reg   <= lead_zeros16(cfg_wdata);
                end
                CFG_GREEN_MASK:
                begin
                    green_mask_reg <= cfg_wdata;
                    green_lz_reg   <= lead_zeros16(cfg_wdata);
                end
                CFG_BLUE_MASK:
                begin
                    blue_mask_reg <= cfg_wdata;
                    blue_lz_reg   <= lead_zeros16(cfg_wdata);
                end
                default:
                begin
                end
            endcase
        end
    end

    // Palette memory: write port and registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr] <= {in_data.red, in_data.green, in_data.blue};
        end
        if (rd_en)
        begin
            mem_rdata_reg <= mem[rd_addr];
        end
    end

    // Scan setup, issue counter, pipeline valids and best entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            issue_cnt_reg <= '0;
            count_reg     <= '0;
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            best_reg      <= BEST_START;
            best_idx_reg  <= '0;
        end
        else
        begin
            v1_reg <= rd_en;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            if (accept && (in_data.op == OP_LOOKUP) && is_palette)
            begin
                issue_cnt_reg <= '0;
                count_reg     <= count_eff;
                best_reg      <= BEST_START;
                best_idx_reg  <= '0;
            end
            else
            begin
                if (rd_en)
                begin
                    issue_cnt_reg <= issue_cnt_reg + 1'b1;
                end
                if (better)
                begin
                    best_reg     <= dist_sum[BEST_W-1:0];
                    best_idx_reg <= idx3_reg;
                end
            end
        end
    end

    // Target color, truncated once at accept
    always_ff @(posedge clk)
    begin
        if (accept && (in_data.op == OP_LOOKUP))
        begin
            sh_reg    <= sh_eff;
            tgt_r_reg <= in_data.red   >> sh_eff;
            tgt_g_reg <= in_data.green >> sh_eff;
            tgt_b_reg <= in_data.blue  >> sh_eff;
        end
    end

    // Datapath stages: differences, then squares
    always_ff @(posedge clk)
    begin
        idx1_reg <= rd_addr;
        idx2_reg <= idx1_reg;
        idx3_reg <= idx2_reg;
        d_r_reg  <= abs_diff(tgt_r_reg, mem_rdata_reg[ENT_W-1:2*CHAN_W] >> sh_reg);
        d_g_reg  <= abs_diff(tgt_g_reg, mem_rdata_reg[2*CHAN_W-1:CHAN_W] >> sh_reg);
        d_b_reg  <= abs_diff(tgt_b_reg, mem_rdata_reg[CHAN_W-1:0] >> sh_reg);
        sq_r_reg <= 32'(d_r_reg) * 32'(d_r_reg);
        sq_g_reg <= 32'(d_g_reg) * 32'(d_g_reg);
        sq_b_reg <= 32'(d_b_reg) * 32'(d_b_reg);
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_data_reg <= out_load_data;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Assertions
    `ASSERT_ALWAYS(a_read_in_range, !rd_en || (CNT_W'(rd_addr) < count_reg), "scan read past palette size")
    `ASSERT_ALWAYS(a_pipe_in_scan, !(v1_reg || v2_reg || v3_reg) || (state_reg == ST_SCAN), "pipeline busy outside scan")
    `ASSERT_ALWAYS(a_best_in_range, (state_reg == ST_IDLE) || (CNT_W'(best_idx_reg) < count_reg), "best index beyond searched entries")
    `ASSERT_NEXT(a_done_delivers, (state_reg == ST_DONE) && slot_free, out_valid_reg && (state_reg == ST_IDLE), "finished search not delivered")

endmodule
